>>> rtl/core/sha1_stream_hasher_top_defines.svh
// Assertion macros shared by the SHA-1 stream hasher RTL.
// Pulled in by the modules that carry concurrent checks; depends on nothing.
`ifndef SHA1_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHA1SH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA1SH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sha1sh_pkg.sv
// Shared types, constants and helper functions of the SHA-1 stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1sh_pkg;

	localparam int ROUNDS     = 80;
	localparam int BLK_BYTES  = 64;
	localparam int LEN_START  = 56;
	localparam int DIG_WORDS  = 5;

	localparam logic [6:0] LAST_ROUND   = 7'(ROUNDS - 1);
	localparam logic [5:0] LAST_BYTE    = 6'(BLK_BYTES - 1);
	localparam logic [5:0] LAST_PAD     = 6'(LEN_START - 1);
	localparam logic [2:0] LAST_WORD    = 3'(DIG_WORDS - 1);
	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	// Initial chaining value, word 0 in the lowest slice
	localparam logic [4:0][31:0] IV = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	// One message request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       is_last;
	} in_t;

	// One digest word request
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_t;

	// Source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		BS_IN,
		BS_PAD,
		BS_ZERO,
		BS_LEN
	} byte_sel_t;

	// Round group: selects the boolean function and the round constant
	typedef enum logic [1:0] {
		RG_CH,
		RG_PAR1,
		RG_MAJ,
		RG_PAR2
	} rgrp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic        shift_en;
		byte_sel_t   byte_sel;
		logic        count_bits;
		logic        start_cmp;
		logic        round_en;
		rgrp_t       grp;
		logic        finalize;
		logic        out_load;
		logic [2:0]  out_idx;
		logic        reload_iv;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [5:0] cnt;
		logic       out_free;
	} sts_t;

	function automatic logic [31:0] round_k(rgrp_t g);
		logic [31:0] k;
		unique case (g)
			RG_CH:   k = 32'h5a827999;
			RG_PAR1: k = 32'h6ed9eba1;
			RG_MAJ:  k = 32'h8f1bbcdc;
			RG_PAR2: k = 32'hca62c1d6;
			default: k = 32'h5a827999;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(rgrp_t g, logic [31:0] b, logic [31:0] c,
		logic [31:0] d);
		logic [31:0] f;
		unique case (g)
			RG_CH:   f = d ^ (b & (c ^ d));
			RG_MAJ:  f = (b & c) | (d & (b | c));
			RG_PAR1,
			RG_PAR2: f = b ^ c ^ d;
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

>>> rtl/core/sha1sh_dpath.sv
// Datapath of the SHA-1 stream hasher: block buffer and message schedule,
// round registers, chaining value, counters and the digest output register.
// Depends on sha1sh_pkg; driven by sha1sh_ctrl through cmd_t.
module sha1sh_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1sh_pkg::in_t   msg_data,
	input  logic              dig_stall,
	input  sha1sh_pkg::cmd_t  cmd,
	output sha1sh_pkg::sts_t  sts,
	output logic              dig_valid,
	output sha1sh_pkg::out_t  dig_data
);

	// Block buffer: oldest word in the top 32 bits
	logic [511:0]      blk_q;
	logic [5:0]        cnt_q;
	logic [63:0]       bitcnt_q;
	logic [4:0][31:0]  cv_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic              dig_valid_q;
	sha1sh_pkg::out_t  dig_q;

	logic [7:0]        byte_d;
	logic [31:0]       w_new;
	logic [31:0]       w_cur;
	logic [31:0]       t_sum;

	// Byte source for the buffer
	always_comb begin
		unique case (cmd.byte_sel)
			sha1sh_pkg::BS_IN:   byte_d = msg_data.data_byte;
			sha1sh_pkg::BS_PAD:  byte_d = sha1sh_pkg::PAD_MARK;
			sha1sh_pkg::BS_ZERO: byte_d = 8'h00;
			sha1sh_pkg::BS_LEN:  byte_d = bitcnt_q[{~cnt_q[2:0], 3'b000} +: 8];
			default:             byte_d = 8'h00;
		endcase
	end

	// Schedule: window word j sits at blk_q[511-32j -: 32]
	assign w_cur = blk_q[511:480];
	always_comb begin
		logic [31:0] x;
		x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
		w_new = {x[30:0], x[31]};
	end

	// Round sum
	assign t_sum = {a_q[26:0], a_q[31:27]}
		+ sha1sh_pkg::round_f(cmd.grp, b_q, c_q, d_q)
		+ e_q + w_cur + sha1sh_pkg::round_k(cmd.grp);

	// Buffer: byte shift on load, word shift during rounds
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_d};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (cmd.start_cmp) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
			e_q <= cv_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			bitcnt_q <= '0;
			cv_q     <= sha1sh_pkg::IV;
		end else begin
			if (cmd.start_cmp || cmd.reload_iv) begin
				cnt_q <= '0;
			end else if (cmd.shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.reload_iv) begin
				bitcnt_q <= '0;
			end else if (cmd.count_bits) begin
				bitcnt_q <= bitcnt_q + sha1sh_pkg::BITS_PER_BYTE;
			end
			if (cmd.reload_iv) begin
				cv_q <= sha1sh_pkg::IV;
			end else if (cmd.finalize) begin
				cv_q[0] <= cv_q[0] + a_q;
				cv_q[1] <= cv_q[1] + b_q;
				cv_q[2] <= cv_q[2] + c_q;
				cv_q[3] <= cv_q[3] + d_q;
				cv_q[4] <= cv_q[4] + e_q;
			end
		end
	end

	// Digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			dig_valid_q <= 1'b1;
		end else if (!dig_stall) begin
			dig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dig_q.digest_word <= cv_q[cmd.out_idx];
			dig_q.word_index  <= cmd.out_idx;
			dig_q.last_word   <= (cmd.out_idx == sha1sh_pkg::LAST_WORD);
		end
	end

	assign dig_valid    = dig_valid_q;
	assign dig_data     = dig_q;
	assign sts.cnt      = cnt_q;
	assign sts.out_free = !dig_valid_q || !dig_stall;

endmodule

>>> rtl/core/sha1sh_ctrl.sv
// Controller of the SHA-1 stream hasher: input handshake, padding sequence,
// round counter and digest word sequencing. Depends on sha1sh_pkg and the
// assertion macros in sha1_stream_hasher_top_defines.svh.
`include "sha1_stream_hasher_top_defines.svh"

module sha1sh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  sha1sh_pkg::in_t   msg_data,
	output logic              msg_stall,
	input  sha1sh_pkg::sts_t  sts,
	output sha1sh_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LEN,
		S_ROUND,
		S_FINAL,
		S_OUT
	} state_t;

	// Where to go once a compression is folded in
	typedef enum logic [1:0] {
		RET_IDLE,
		RET_PAD,
		RET_OUT
	} ret_t;

	state_t      state_q, state_d;
	ret_t        ret_q, ret_d;
	logic [6:0]  rnd_q;
	logic [2:0]  widx_q;
	logic        pad_first_q;
	logic        acc;

	assign acc       = msg_valid && (state_q == S_IDLE);
	assign msg_stall = (state_q != S_IDLE);

	// Commands and next state
	always_comb begin
		state_d        = state_q;
		ret_d          = ret_q;
		cmd.shift_en   = 1'b0;
		cmd.byte_sel   = sha1sh_pkg::BS_IN;
		cmd.count_bits = 1'b0;
		cmd.start_cmp  = 1'b0;
		cmd.round_en   = 1'b0;
		cmd.grp        = sha1sh_pkg::RG_CH;
		cmd.finalize   = 1'b0;
		cmd.out_load   = 1'b0;
		cmd.out_idx    = widx_q;
		cmd.reload_iv  = 1'b0;

		if (rnd_q < 7'd20) begin
			cmd.grp = sha1sh_pkg::RG_CH;
		end else if (rnd_q < 7'd40) begin
			cmd.grp = sha1sh_pkg::RG_PAR1;
		end else if (rnd_q < 7'd60) begin
			cmd.grp = sha1sh_pkg::RG_MAJ;
		end else begin
			cmd.grp = sha1sh_pkg::RG_PAR2;
		end

		unique case (state_q)
			S_IDLE: begin
				if (acc && msg_data.byte_present) begin
					cmd.shift_en   = 1'b1;
					cmd.byte_sel   = sha1sh_pkg::BS_IN;
					cmd.count_bits = 1'b1;
					if (sts.cnt == sha1sh_pkg::LAST_BYTE) begin
						cmd.start_cmp = 1'b1;
						state_d       = S_ROUND;
						ret_d         = msg_data.is_last ? RET_PAD : RET_IDLE;
					end else if (msg_data.is_last) begin
						state_d = S_PAD;
					end
				end else if (acc && msg_data.is_last) begin
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = pad_first_q ? sha1sh_pkg::BS_PAD : sha1sh_pkg::BS_ZERO;
				if (sts.cnt == sha1sh_pkg::LAST_BYTE) begin
					cmd.start_cmp = 1'b1;
					state_d       = S_ROUND;
					ret_d         = RET_PAD;
				end else if (sts.cnt == sha1sh_pkg::LAST_PAD) begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = sha1sh_pkg::BS_LEN;
				if (sts.cnt == sha1sh_pkg::LAST_BYTE) begin
					cmd.start_cmp = 1'b1;
					state_d       = S_ROUND;
					ret_d         = RET_OUT;
				end
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == sha1sh_pkg::LAST_ROUND) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.finalize = 1'b1;
				unique case (ret_q)
					RET_IDLE: state_d = S_IDLE;
					RET_PAD:  state_d = S_PAD;
					RET_OUT:  state_d = S_OUT;
					default:  state_d = S_IDLE;
				endcase
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (widx_q == sha1sh_pkg::LAST_WORD) begin
						cmd.reload_iv = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_IDLE;
			rnd_q       <= '0;
			widx_q      <= '0;
			pad_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == S_ROUND) begin
				rnd_q <= (rnd_q == sha1sh_pkg::LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
			end
			if (cmd.out_load) begin
				widx_q <= (widx_q == sha1sh_pkg::LAST_WORD) ? 3'd0 : widx_q + 3'd1;
			end
			if (acc && msg_data.is_last) begin
				pad_first_q <= 1'b1;
			end else if (state_q == S_PAD) begin
				pad_first_q <= 1'b0;
			end
		end
	end

	// Checks
	`SHA1SH_ASSERT_NOW(a_cmp_on_full, clk, arst_n, cmd.start_cmp, sts.cnt == sha1sh_pkg::LAST_BYTE, "compression started on a partial block")
	`SHA1SH_ASSERT_NOW(a_load_free, clk, arst_n, cmd.out_load, sts.out_free, "digest word loaded over a waiting word")
	`SHA1SH_ASSERT_NEXT(a_final_out, clk, arst_n, (state_q == S_FINAL) && (ret_q == RET_OUT), state_q == S_OUT, "closing compression not followed by digest output")
	`SHA1SH_ASSERT_NOW(a_rnd_idle, clk, arst_n, state_q != S_ROUND, rnd_q == 7'd0, "round counter not at zero outside compression")

endmodule

>>> rtl/core/sha1_stream_hasher_top.sv
// Top level of the SHA-1 stream hasher: joins controller and datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_dpath.
//
// Usage: message bytes enter on the msg channel (msg_valid, msg_stall,
// msg_data), one request per byte; byte_present qualifies data_byte and
// is_last closes the message, with or without a byte on that request.
// Five digest words leave on the dig channel (dig_valid, dig_stall,
// dig_data), word_index 0 first, last_word set on word 4.
// A byte that fills a 64-byte block holds the input off during its
// compression (80 rounds at one round per cycle, then the chaining add), so
// a long message is paced by the single round unit. Closing a message
// shifts in the padding and length one byte per cycle (9 to 64 bytes, 65
// to 72 when a second block is needed), compresses once or twice, then
// loads one digest word per cycle into the output register while it is free.
// The digest words follow each other through a one-deep output register;
// while a word waits and dig_stall is high, the word and the sequencer
// hold. After the fifth word is loaded the initial value is back and the
// next message is taken, even while that word still waits.
// Reset (arst_n low) loads the initial value, clears the counters and
// empties the output register.
module sha1_stream_hasher_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sha1sh_pkg::in_t   msg_data,
	output logic              dig_valid,
	input  logic              dig_stall,
	output sha1sh_pkg::out_t  dig_data
);

	sha1sh_pkg::cmd_t cmd;
	sha1sh_pkg::sts_t sts;

	// Sequencer
	sha1sh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_data  (msg_data),
		.msg_stall (msg_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hash datapath
	sha1sh_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_data  (msg_data),
		.dig_stall (dig_stall),
		.cmd       (cmd),
		.sts       (sts),
		.dig_valid (dig_valid),
		.dig_data  (dig_data)
	);

endmodule
